### rtl/arck_pkg.sv
// ----------------------------------------------------------------------------
// arck_pkg
// Types, constants and AES helper functions shared by the keystream unit.
// ----------------------------------------------------------------------------
package arck_pkg;

    localparam int KEY_HALF_W = 64;
    localparam int COUNT_W    = 7;
    localparam int REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_KEY_FIRST  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_KEY_SECOND = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_START_CNT  = 2'd2;

    localparam logic [7:0]   PLAIN_BYTE  = 8'h30;
    localparam logic [127:0] PLAIN_BLOCK = {16{PLAIN_BYTE}};
    localparam logic [3:0]   LAST_ROUND  = 4'd10;

    typedef struct packed {
        logic                   restart;
        logic [COUNT_W-1:0]     block_count;
    } req_t;

    typedef struct packed {
        logic [KEY_HALF_W-1:0]  keystream_first_half;
        logic [KEY_HALF_W-1:0]  keystream_second_half;
        logic                   last_block;
    } rsp_t;

    typedef struct packed {
        logic                   restart;
        logic [COUNT_W-1:0]     count;
    } job_t;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
        };
        return t[x];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of a block sits at bits [8i+7:8i]
    function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
        logic [127:0] n;
        logic [31:0]  t;
        t = {sbox(k[103:96]), sbox(k[127:120]), sbox(k[119:112]),
             sbox(k[111:104]) ^ rc};
        n[31:0]   = k[31:0]   ^ t;
        n[63:32]  = k[63:32]  ^ n[31:0];
        n[95:64]  = k[95:64]  ^ n[63:32];
        n[127:96] = k[127:96] ^ n[95:64];
        return n;
    endfunction

    function automatic logic [127:0] enc_round(input logic [127:0] s,
                                               input logic [127:0] rk,
                                               input logic         final_rnd);
        logic [127:0] t;
        logic [127:0] m;
        logic [7:0]   a0, a1, a2, a3, x;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[(c*4+r)*8 +: 8] = sbox(s[((((c+r)&3)*4)+r)*8 +: 8]);
        m = t;
        if (!final_rnd)
        begin
            for (int c = 0; c < 4; c++)
            begin
                a0 = t[(c*4)*8 +: 8];
                a1 = t[(c*4+1)*8 +: 8];
                a2 = t[(c*4+2)*8 +: 8];
                a3 = t[(c*4+3)*8 +: 8];
                x  = a0 ^ a1 ^ a2 ^ a3;
                m[(c*4)*8 +: 8]   = a0 ^ x ^ xtime(a0 ^ a1);
                m[(c*4+1)*8 +: 8] = a1 ^ x ^ xtime(a1 ^ a2);
                m[(c*4+2)*8 +: 8] = a2 ^ x ^ xtime(a2 ^ a3);
                m[(c*4+3)*8 +: 8] = a3 ^ x ^ xtime(a3 ^ a0);
            end
        end
        return m ^ rk;
    endfunction

endpackage

### rtl/arck_front.sv
// ----------------------------------------------------------------------------
// arck_front
// Accepts requests, saturates the count and queues them for the back end.
// ----------------------------------------------------------------------------
module arck_front #(
    parameter int MAX_BLOCKS = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  arck_pkg::req_t in_req,
    output logic           job_valid,
    input  logic           job_take,
    output arck_pkg::job_t job
);
    import arck_pkg::*;

    job_t       q_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;
    job_t       nj;

    assign in_stall  = (cnt_reg == 2'd2);
    assign push      = in_valid && !in_stall;
    assign job_valid = (cnt_reg != 2'd0);
    assign pop       = job_valid && job_take;
    assign job       = q_reg[rp_reg];

    always_comb
    begin
        nj.restart = in_req.restart;
        nj.count   = (in_req.block_count > COUNT_W'(MAX_BLOCKS)) ?
                     COUNT_W'(MAX_BLOCKS) : in_req.block_count;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wp_reg] <= nj;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= !wp_reg;
            if (pop)  rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

### rtl/arck_back.sv
// ----------------------------------------------------------------------------
// arck_back
// Runs AES-128 one round per cycle with on-the-fly key expansion per block.
// ----------------------------------------------------------------------------
module arck_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_valid,
    output logic           job_take,
    input  arck_pkg::job_t job,
    input  logic [63:0]    key_first_half,
    input  logic [63:0]    key_second_half,
    input  logic [63:0]    start_counter,
    output logic           out_valid,
    input  logic           out_stall,
    output arck_pkg::rsp_t out_rsp
);
    import arck_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_INIT = 2'd1;
    localparam logic [1:0] ST_RND  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]         st_reg;
    logic [63:0]        ctr_reg;
    logic [COUNT_W-1:0] left_reg;
    logic [3:0]         rnd_reg;
    logic [7:0]         rc_reg;
    logic [127:0]       rk_reg, s_reg;
    logic               ov_reg;
    rsp_t               rsp_reg;
    logic [127:0]       k0, rk_n;

    assign k0       = {key_second_half, key_first_half ^ ctr_reg};
    assign rk_n     = key_step(rk_reg, rc_reg);
    assign job_take = (st_reg == ST_IDLE);
    assign out_valid = ov_reg;
    assign out_rsp   = rsp_reg;

    always_ff @(posedge clk)
    begin
        unique case (st_reg)
            ST_INIT:
            begin
                rk_reg <= k0;
                s_reg  <= PLAIN_BLOCK ^ k0;
                rc_reg <= 8'h01;
            end
            ST_RND:
            begin
                rk_reg <= rk_n;
                s_reg  <= enc_round(s_reg, rk_n, rnd_reg == LAST_ROUND);
                rc_reg <= xtime(rc_reg);
            end
            default:
            begin
            end
        endcase
        if (st_reg == ST_OUT && !(ov_reg && out_stall))
        begin
            rsp_reg.keystream_first_half  <= s_reg[63:0];
            rsp_reg.keystream_second_half <= s_reg[127:64];
            rsp_reg.last_block            <= (left_reg == COUNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_IDLE;
            ctr_reg  <= '0;
            left_reg <= '0;
            rnd_reg  <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            if (st_reg == ST_OUT && !(ov_reg && out_stall))
                ov_reg <= 1'b1;
            else if (ov_reg && !out_stall)
                ov_reg <= 1'b0;
            unique case (st_reg)
                ST_IDLE:
                begin
                    if (job_valid)
                    begin
                        if (job.restart)
                            ctr_reg <= start_counter;
                        left_reg <= job.count;
                        if (job.count != '0)
                            st_reg <= ST_INIT;
                    end
                end
                ST_INIT:
                begin
                    rnd_reg <= 4'd1;
                    st_reg  <= ST_RND;
                end
                ST_RND:
                begin
                    rnd_reg <= rnd_reg + 4'd1;
                    if (rnd_reg == LAST_ROUND)
                        st_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!(ov_reg && out_stall))
                    begin
                        ctr_reg  <= ctr_reg + 64'd1;
                        left_reg <= left_reg - COUNT_W'(1);
                        st_reg   <= (left_reg == COUNT_W'(1)) ? ST_IDLE : ST_INIT;
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

### rtl/aes_rekeyed_counter_keystream_unit.sv
// ----------------------------------------------------------------------------
// aes_rekeyed_counter_keystream_unit
// AES-128 keystream generator, key rekeyed by a 64-bit block counter.
// ----------------------------------------------------------------------------
// Use: write the key halves and start counter through cfg_we/cfg_index/
// cfg_data while idle. Each request (in_valid/in_stall) carries restart and
// block_count; block_count above MAX_BLOCKS is clipped. Each request yields
// one result per block on out_valid/out_stall, last_block on the final one.
// A two-entry request queue lets new requests in while blocks are produced.
// Each block is loaded, run through ten rounds of the single round unit with
// its key schedule step, and handed off to the output register; a request is
// first picked off the queue while the back end is idle.
// A stalled receiver holds the output register; the round unit then waits.
// Reset clears the config registers, the counter and the queue; zero-block
// requests only apply restart and produce nothing.
// ----------------------------------------------------------------------------
module aes_rekeyed_counter_keystream_unit #(
    parameter int MAX_BLOCKS = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  arck_pkg::req_t in_req,
    output logic           out_valid,
    input  logic           out_stall,
    output arck_pkg::rsp_t out_rsp,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_index,
    input  logic [63:0]    cfg_data
);
    import arck_pkg::*;

    logic [63:0] kf_reg, ks_reg, sc_reg;
    logic        job_valid, job_take;
    job_t        job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kf_reg <= '0;
            ks_reg <= '0;
            sc_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KEY_FIRST:  kf_reg <= cfg_data;
                REG_KEY_SECOND: ks_reg <= cfg_data;
                REG_START_CNT:  sc_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    arck_front #(.MAX_BLOCKS(MAX_BLOCKS)) u_front (
        .clk, .rst_n, .in_valid, .in_stall, .in_req,
        .job_valid, .job_take, .job
    );

    arck_back u_back (
        .clk, .rst_n, .job_valid, .job_take, .job,
        .key_first_half(kf_reg), .key_second_half(ks_reg), .start_counter(sc_reg),
        .out_valid, .out_stall, .out_rsp
    );

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_rsp))
        else $error("output changed under stall");
    a_queue_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> job_valid)
        else $error("stall with empty queue");
`endif

endmodule
